[hdl/bldc_ramp_pkg.sv]
// shared types, constants and helpers for the startup ramp sequencer
package bldc_ramp_pkg;

  localparam int unsigned CURRENT_BITS = 10;
  localparam int unsigned TICK_BITS    = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned PERIOD_W     = 10;

  // period / 15 as a multiply by reciprocal, exact for 10 bit periods
  localparam int unsigned DIV15_RECIP  = 2185;
  localparam int unsigned DIV15_SHIFT  = 15;
  localparam int unsigned PROD_W       = PERIOD_W + 12;

  localparam logic [2:0] LAST_PHASE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_START_PWM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_PWM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_TICK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_END_PER    = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_PROBE = 3'd1,
    MODE_RAMP  = 3'd2,
    MODE_DONE  = 3'd3,
    MODE_FAIL  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0]          start_pwm;
    logic [7:0]          probe_pwm;
    logic [15:0]         probe_ticks;
    logic [9:0]          probe_current_limit;
    logic [9:0]          run_current_limit;
    logic [PERIOD_W-1:0] initial_period;
    logic [PERIOD_W-1:0] end_period;
  } cfg_t;

  typedef struct packed {
    mode_e      status;
    logic [7:0] pwm_duty;
    logic       drive_enable;
    logic       commutate;
    logic [2:0] commutation_step;
  } res_t;

  function automatic logic [PERIOD_W-1:0] period_shrink(logic [PERIOD_W-1:0] p);
    logic [PROD_W-1:0]   prod;
    logic [PERIOD_W-1:0] dec;
    prod = PROD_W'(p) * PROD_W'(DIV15_RECIP);
    dec  = PERIOD_W'(prod >> DIV15_SHIFT) + PERIOD_W'(1);
    return (p > dec) ? (p - dec) : '0;
  endfunction

endpackage

[hdl/bldc_ramp_cfg.sv]
// configuration register bank
module bldc_ramp_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bldc_ramp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bldc_ramp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bldc_ramp_pkg::cfg_t                  cfg_o
);
  import bldc_ramp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_pwm           <= 8'd40;
      cfg_q.probe_pwm           <= 8'd5;
      cfg_q.probe_ticks         <= 16'd3000;
      cfg_q.probe_current_limit <= 10'd190;
      cfg_q.run_current_limit   <= 10'd200;
      cfg_q.initial_period      <= PERIOD_W'(300);
      cfg_q.end_period          <= PERIOD_W'(25);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_PWM:  cfg_q.start_pwm           <= cfg_data_i[7:0];
        CFG_PROBE_PWM:  cfg_q.probe_pwm           <= cfg_data_i[7:0];
        CFG_PROBE_TICK: cfg_q.probe_ticks         <= cfg_data_i[15:0];
        CFG_PROBE_LIM:  cfg_q.probe_current_limit <= cfg_data_i[9:0];
        CFG_RUN_LIM:    cfg_q.run_current_limit   <= cfg_data_i[9:0];
        CFG_INIT_PER:   cfg_q.initial_period      <= cfg_data_i[PERIOD_W-1:0];
        CFG_END_PER:    cfg_q.end_period          <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/bldc_ramp_core.sv]
// sequencer state and per-request update logic
module bldc_ramp_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  logic                                  cmd_i,
  input  logic [bldc_ramp_pkg::CURRENT_BITS-1:0] cur_i,
  input  bldc_ramp_pkg::cfg_t                    cfg_i,
  output bldc_ramp_pkg::res_t                    res_o
);
  import bldc_ramp_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [TICK_BITS-1:0]  tick_q, tick_d, tick_inc;
  logic [PERIOD_W-1:0]   period_q, period_d, period_new;
  logic [2:0]            phase_q, phase_d;
  logic [7:0]            duty_q, duty_d;
  logic                  comm;
  logic [2:0]            step;

  always_comb begin
    mode_d     = mode_q;
    tick_d     = tick_q;
    period_d   = period_q;
    phase_d    = phase_q;
    duty_d     = duty_q;
    comm       = 1'b0;
    step       = 3'd0;
    tick_inc   = (tick_q != '1) ? (tick_q + TICK_BITS'(1)) : tick_q;
    period_new = (period_q >= cfg_i.end_period) ? period_shrink(period_q) : period_q;
    if (fire_i) begin
      if (cmd_i) begin
        duty_d = cfg_i.probe_pwm;
        comm   = 1'b1;
        step   = phase_q;
        tick_d = '0;
        mode_d = MODE_PROBE;
      end else begin
        case (mode_q)
          MODE_PROBE: begin
            if (32'(cur_i) > 32'(cfg_i.probe_current_limit)) begin
              mode_d = MODE_FAIL;
              duty_d = '0;
            end else if (32'(tick_inc) >= 32'(cfg_i.probe_ticks)) begin
              duty_d   = cfg_i.start_pwm;
              phase_d  = '0;
              period_d = cfg_i.initial_period;
              tick_d   = '0;
              mode_d   = MODE_RAMP;
            end else begin
              tick_d = tick_inc;
            end
          end
          MODE_RAMP: begin
            if (32'(tick_inc) >= 32'(period_q)) begin
              tick_d = '0;
              if (32'(cur_i) > 32'(cfg_i.run_current_limit)) begin
                mode_d = MODE_FAIL;
                duty_d = '0;
              end else begin
                period_d = period_new;
                if (period_new < cfg_i.end_period) begin
                  mode_d = MODE_DONE;
                end else begin
                  comm    = 1'b1;
                  step    = phase_q;
                  phase_d = (phase_q == LAST_PHASE) ? 3'd0 : (phase_q + 3'd1);
                  duty_d  = cfg_i.start_pwm;
                end
              end
            end else begin
              tick_d = tick_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      tick_q   <= '0;
      period_q <= '0;
      phase_q  <= '0;
      duty_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      tick_q   <= tick_d;
      period_q <= period_d;
      phase_q  <= phase_d;
      duty_q   <= duty_d;
    end
  end

  always_comb begin
    res_o.status           = mode_d;
    res_o.pwm_duty         = duty_d;
    res_o.drive_enable     = mode_d inside {MODE_PROBE, MODE_RAMP, MODE_DONE};
    res_o.commutate        = comm;
    res_o.commutation_step = step;
  end

endmodule

[hdl/bldc_open_loop_startup_ramp_top.sv]
// top level of the open-loop startup ramp sequencer
// an accepted request waits in the input register; its result is then captured in the result register
// throughput: one request per cycle while results are taken, set by the input register feeding the result register
// a stalled result holds the input register; one further request waits there
// reset (async, active low): idle mode, zero counters, default configuration, no result
module bldc_open_loop_startup_ramp_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bldc_ramp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bldc_ramp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  in_command_i,
  input  logic [bldc_ramp_pkg::CURRENT_BITS-1:0] in_current_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [2:0]                            out_status_o,
  output logic [7:0]                            out_pwm_duty_o,
  output logic                                  out_drive_enable_o,
  output logic                                  out_commutate_o,
  output logic [2:0]                            out_commutation_step_o
);
  import bldc_ramp_pkg::*;

  cfg_t                    cfg;
  res_t                    res;
  res_t                    res_q;
  logic                    s1_valid_q;
  logic                    s1_cmd_q;
  logic [CURRENT_BITS-1:0] s1_cur_q;
  logic                    out_valid_q;
  logic                    out_free;
  logic                    s1_adv;
  logic                    in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  bldc_ramp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bldc_ramp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_adv),
    .cmd_i  (s1_cmd_q),
    .cur_i  (s1_cur_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q <= in_command_i;
      s1_cur_q <= in_current_i;
    end
    if (s1_adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_status_o           = res_q.status;
  assign out_pwm_duty_o         = res_q.pwm_duty;
  assign out_drive_enable_o     = res_q.drive_enable;
  assign out_commutate_o        = res_q.commutate;
  assign out_commutation_step_o = res_q.commutation_step;

`ifndef SYNTHESIS
  a_comm_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_commutate_o |-> out_drive_enable_o)
    else $error("commutation issued with drive disabled");

  a_fail_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == MODE_FAIL) |-> !out_drive_enable_o &&
    (out_pwm_duty_o == 8'd0))
    else $error("failed state still driving");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_commutate_o |-> (out_commutation_step_o <= LAST_PHASE))
    else $error("commutation step out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("request refused without a stalled result");
`endif

endmodule

[test/bldc_open_loop_startup_ramp_top_test.sv]
// self-checking testbench for the open-loop startup ramp sequencer top level
module bldc_open_loop_startup_ramp_top_test;
  import bldc_ramp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned SHRINK_DIV   = 15;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_GAP    = 4;
  localparam int unsigned PHASE_ITEMS  = 130;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i   = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic                    in_command_i = 1'b0;
  logic [CURRENT_BITS-1:0] in_current_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [2:0]              out_status_o;
  logic [7:0]              out_pwm_duty_o;
  logic                    out_drive_enable_o;
  logic                    out_commutate_o;
  logic [2:0]              out_commutation_step_o;

  bldc_open_loop_startup_ramp_top uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .in_command_i           (in_command_i),
    .in_current_i           (in_current_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .out_status_o           (out_status_o),
    .out_pwm_duty_o         (out_pwm_duty_o),
    .out_drive_enable_o     (out_drive_enable_o),
    .out_commutate_o        (out_commutate_o),
    .out_commutation_step_o (out_commutation_step_o)
  );

  always #5 clk_i = ~clk_i;

  // sequencer state as predicted
  cfg_t                seq_cfg;
  mode_e               seq_mode;
  logic [TICK_BITS-1:0] seq_ticks;
  logic [PERIOD_W-1:0] seq_period;
  logic [2:0]          seq_phase;
  logic [7:0]          seq_duty;

  res_t res_due[$];
  int unsigned sent_items   = 0;
  int unsigned fail_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len  = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;

  function automatic res_t step_sequencer(logic cmd, logic [CURRENT_BITS-1:0] cur);
    res_t                r;
    logic [PERIOD_W-1:0] dec;
    logic                comm;
    logic [2:0]          step;
    comm = 1'b0;
    step = 3'd0;
    if (cmd) begin
      seq_duty  = seq_cfg.probe_pwm;
      comm      = 1'b1;
      step      = seq_phase;
      seq_ticks = '0;
      seq_mode  = MODE_PROBE;
    end else if (seq_mode == MODE_PROBE) begin
      if (cur > seq_cfg.probe_current_limit) begin
        seq_mode = MODE_FAIL;
        seq_duty = '0;
      end else begin
        if (seq_ticks != '1) seq_ticks++;
        if (seq_ticks >= seq_cfg.probe_ticks) begin
          seq_duty   = seq_cfg.start_pwm;
          seq_phase  = 3'd0;
          seq_period = seq_cfg.initial_period;
          seq_ticks  = '0;
          seq_mode   = MODE_RAMP;
        end
      end
    end else if (seq_mode == MODE_RAMP) begin
      if (seq_ticks != '1) seq_ticks++;
      if (seq_ticks >= TICK_BITS'(seq_period)) begin
        seq_ticks = '0;
        if (cur > seq_cfg.run_current_limit) begin
          seq_mode = MODE_FAIL;
          seq_duty = '0;
        end else begin
          if (seq_period >= seq_cfg.end_period) begin
            dec = PERIOD_W'(seq_period / SHRINK_DIV) + PERIOD_W'(1);
            seq_period = (seq_period > dec) ? (seq_period - dec) : '0;
          end
          if (seq_period < seq_cfg.end_period) begin
            seq_mode = MODE_DONE;
          end else begin
            comm      = 1'b1;
            step      = seq_phase;
            seq_phase = (seq_phase == LAST_PHASE) ? 3'd0 : seq_phase + 3'd1;
            seq_duty  = seq_cfg.start_pwm;
          end
        end
      end
    end
    r.status           = seq_mode;
    r.pwm_duty         = seq_duty;
    r.drive_enable     = (seq_mode == MODE_PROBE || seq_mode == MODE_RAMP ||
                          seq_mode == MODE_DONE);
    r.commutate        = comm;
    r.commutation_step = step;
    return r;
  endfunction

  task automatic send_req(input logic cmd, input logic [CURRENT_BITS-1:0] cur);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_command_i <= cmd;
    in_current_i <= cur;
    do @(posedge clk_i); while (!in_ready_o);
    res_due.push_back(step_sequencer(cmd, cur));
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (res_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_START_PWM:  seq_cfg.start_pwm           = data[7:0];
      CFG_PROBE_PWM:  seq_cfg.probe_pwm           = data[7:0];
      CFG_PROBE_TICK: seq_cfg.probe_ticks         = data[15:0];
      CFG_PROBE_LIM:  seq_cfg.probe_current_limit = data[9:0];
      CFG_RUN_LIM:    seq_cfg.run_current_limit   = data[9:0];
      CFG_INIT_PER:   seq_cfg.initial_period      = data[PERIOD_W-1:0];
      CFG_END_PER:    seq_cfg.end_period          = data[PERIOD_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // unused upper data bits carry noise
  task automatic apply_config(input cfg_t c, input bit poke_unused);
    drain();
    write_reg(CFG_START_PWM,  {8'($urandom), c.start_pwm});
    write_reg(CFG_PROBE_PWM,  {8'($urandom), c.probe_pwm});
    write_reg(CFG_PROBE_TICK, c.probe_ticks);
    write_reg(CFG_PROBE_LIM,  {6'($urandom), c.probe_current_limit});
    write_reg(CFG_RUN_LIM,    {6'($urandom), c.run_current_limit});
    write_reg(CFG_INIT_PER,   {6'($urandom), c.initial_period});
    write_reg(CFG_END_PER,    {6'($urandom), c.end_period});
    if (poke_unused) write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    drain();
    @(posedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk_i);
  endtask

  function automatic logic [9:0] rand_limit();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'd1023;
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int unsigned r;
    c.start_pwm = 8'($urandom);
    c.probe_pwm = 8'($urandom);
    c.probe_ticks = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
    c.probe_current_limit = rand_limit();
    c.run_current_limit   = rand_limit();
    c.initial_period = ($urandom_range(0, 9) == 0) ? 10'd1 : 10'($urandom_range(2, 16));
    r = $urandom_range(0, 9);
    if (r == 0) c.end_period = 10'd0;
    else if (r == 1) c.end_period = 10'($urandom_range(c.initial_period, 1023));
    else c.end_period = 10'($urandom_range(1, c.initial_period));
    return c;
  endfunction

  // mostly below the limit that applies in the present mode
  function automatic logic [CURRENT_BITS-1:0] pick_current();
    int unsigned r;
    logic [9:0] lim;
    r   = $urandom_range(0, 99);
    lim = (seq_mode == MODE_RAMP) ? seq_cfg.run_current_limit : seq_cfg.probe_current_limit;
    if (r < 88) return CURRENT_BITS'($urandom_range(0, lim));
    if (r < 94 && lim != 10'd1023) return CURRENT_BITS'($urandom_range(lim + 1, 1023));
    return CURRENT_BITS'($urandom_range(0, 1023));
  endfunction

  // defaults after reset, ignored ticks, probe overcurrent, restarts
  task automatic test_probe_abort();
    send_req(1'b0, 10'd0);
    send_req(1'b0, 10'd1023);
    send_req(1'b1, 10'd0);
    send_req(1'b0, 10'd190);
    send_req(1'b1, 10'd1023);
    send_req(1'b0, 10'd191);
    send_req(1'b0, 10'd1023);
    send_req(1'b1, 10'd512);
  endtask

  // zero probe window and a short ramp to done, then restart from done
  task automatic test_short_ramp();
    cfg_t c;
    c = '{start_pwm: 8'd255, probe_pwm: 8'd0, probe_ticks: 16'd0,
          probe_current_limit: 10'd1023, run_current_limit: 10'd1023,
          initial_period: 10'd3, end_period: 10'd1};
    apply_config(c, 1'b1);
    send_req(1'b1, 10'd0);
    repeat (8) send_req(1'b0, 10'd1023);
    send_req(1'b1, 10'd0);
    send_req(1'b0, 10'd341);
  endtask

  // zero end period commutates every tick; restart mid ramp; run overcurrent
  task automatic test_endless_ramp();
    cfg_t c;
    c = '{start_pwm: 8'd0, probe_pwm: 8'd255, probe_ticks: 16'd1,
          probe_current_limit: 10'd0, run_current_limit: 10'd0,
          initial_period: 10'd1, end_period: 10'd0};
    apply_config(c, 1'b0);
    send_req(1'b1, 10'd682);
    send_req(1'b0, 10'd0);
    repeat (8) send_req(1'b0, 10'd0);
    send_req(1'b1, 10'd0);
    send_req(1'b0, 10'd0);
    send_req(1'b0, 10'd0);
    send_req(1'b0, 10'd1);
  endtask

  task automatic test_backpressure();
    apply_config(rand_cfg(), 1'b0);
    @(posedge clk_i);
    hold_len = HOLD_CYCLES;
    @(negedge clk_i);
    send_req(1'b1, 10'($urandom));
    repeat (60) send_req(1'b0, pick_current());
  endtask

  task automatic test_random_startups();
    int unsigned goal;
    int unsigned n;
    goal = sent_items + PHASE_ITEMS;
    while (sent_items < goal) begin
      apply_config(rand_cfg(), $urandom_range(0, 7) == 0);
      send_req(1'b1, 10'($urandom));
      n = $urandom_range(15, 70);
      repeat (n) begin
        if ($urandom_range(0, 99) < 3) send_req(1'b1, 10'($urandom));
        else send_req(1'b0, pick_current());
      end
    end
  endtask

  // long probe window and a wide period that ends the ramp at its first step
  task automatic test_long_windows();
    cfg_t c;
    c = '{start_pwm: 8'($urandom), probe_pwm: 8'($urandom), probe_ticks: 16'd30,
          probe_current_limit: 10'd1023, run_current_limit: 10'd1023,
          initial_period: 10'd60, end_period: 10'd60};
    apply_config(c, 1'b0);
    send_req(1'b1, 10'($urandom));
    repeat (30) send_req(1'b0, 10'($urandom));
    repeat (64) send_req(1'b0, 10'($urandom));
  endtask

  initial begin
    seq_cfg = '{start_pwm: 8'd40, probe_pwm: 8'd5, probe_ticks: 16'd3000,
                probe_current_limit: 10'd190, run_current_limit: 10'd200,
                initial_period: 10'd300, end_period: 10'd25};
    seq_mode   = MODE_IDLE;
    seq_ticks  = '0;
    seq_period = '0;
    seq_phase  = '0;
    seq_duty   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_idling(8, 62);
    test_probe_abort();
    test_short_ramp();
    test_endless_ramp();
    test_backpressure();
    test_random_startups();
    set_idling(62, 8);
    test_random_startups();
    set_idling(0, 0);
    test_random_startups();
    test_long_windows();
    drain();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && res_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (res_due.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        want = res_due.pop_front();
        if (out_status_o !== 3'(want.status)) begin
          $error("status: expected %0d, got %0d", want.status, out_status_o);
          fail_cnt++;
        end
        if (out_pwm_duty_o !== want.pwm_duty) begin
          $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, out_pwm_duty_o);
          fail_cnt++;
        end
        if (out_drive_enable_o !== want.drive_enable) begin
          $error("drive_enable: expected %0d, got %0d", want.drive_enable,
                 out_drive_enable_o);
          fail_cnt++;
        end
        if (out_commutate_o !== want.commutate) begin
          $error("commutate: expected %0d, got %0d", want.commutate, out_commutate_o);
          fail_cnt++;
        end
        if (out_commutation_step_o !== want.commutation_step) begin
          $error("commutation_step: expected %0d, got %0d", want.commutation_step,
                 out_commutation_step_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
